FILE: rtl/gregorian_date_add_days_unit_macros.svh
// assertion macros used by the checker of the date adder
// no dependencies; include by bare file name
`ifndef GREGORIAN_DATE_ADD_DAYS_UNIT_MACROS_SVH
`define GREGORIAN_DATE_ADD_DAYS_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define GDAD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("date adder check failed");

// next-cycle implication, disabled while reset is asserted
`define GDAD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("date adder check failed");

`endif

FILE: rtl/gdad_pkg.sv
// types, constants, microcode table and calendar functions of the date adder
// no dependencies; used by the sequencer, the top level and the checker
package gdad_pkg;

    localparam logic [13:0] YEAR_MAX     = 14'd9999;
    localparam logic [3:0]  MONTH_MAX    = 4'd12;
    localparam logic [4:0]  DAY_MAX      = 5'd31;
    // y / 100 == (y * RECIP_MUL) >> RECIP_SHIFT for every y up to 9999
    localparam logic [12:0] RECIP_MUL    = 13'd5243;
    localparam int          RECIP_SHIFT  = 19;
    localparam logic [6:0]  CENTURY      = 7'd100;
    localparam logic [8:0]  DAYS_COMMON  = 9'd365;
    localparam logic [8:0]  DAYS_LEAP    = 9'd366;

    typedef struct packed {
        logic [4:0]  start_day;
        logic [3:0]  start_month;
        logic [13:0] start_year;
        logic [15:0] days_to_add;
    } in_beat_t;

    typedef struct packed {
        logic [4:0]  result_day;
        logic [3:0]  result_month;
        logic [13:0] result_year;
        logic        year_overflow;
    } out_beat_t;

    typedef enum logic [3:0] {
        STEP_WAIT,
        STEP_QDIV,
        STEP_REM,
        STEP_DCLAMP,
        STEP_OFFSET,
        STEP_FIRST,
        STEP_YLOOP,
        STEP_MINIT,
        STEP_MLOOP,
        STEP_EMIT,
        STEP_RETURN
    } step_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_QDIV,
        OP_REM,
        OP_DCLAMP,
        OP_OFFSET,
        OP_FIRST,
        OP_YLOOP,
        OP_MINIT,
        OP_MLOOP,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_FIT_FIRST,
        COND_YEAR_MORE,
        COND_MONTH_MORE,
        COND_OUT_BUSY
    } cond_t;

    // one control word: datapath op, jump condition, jump target
    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        step_t  target;
    } ucode_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic fit_first;
        logic year_more;
        logic month_more;
        logic out_busy;
    } status_t;

    // microprogram: jump to target when the condition holds, else fall through
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        case (s)
            STEP_WAIT:   w = '{OP_LOAD,   COND_NO_INPUT,   STEP_WAIT};
            STEP_QDIV:   w = '{OP_QDIV,   COND_NEVER,      STEP_WAIT};
            STEP_REM:    w = '{OP_REM,    COND_NEVER,      STEP_WAIT};
            STEP_DCLAMP: w = '{OP_DCLAMP, COND_NEVER,      STEP_WAIT};
            STEP_OFFSET: w = '{OP_OFFSET, COND_NEVER,      STEP_WAIT};
            STEP_FIRST:  w = '{OP_FIRST,  COND_FIT_FIRST,  STEP_MINIT};
            STEP_YLOOP:  w = '{OP_YLOOP,  COND_YEAR_MORE,  STEP_YLOOP};
            STEP_MINIT:  w = '{OP_MINIT,  COND_NEVER,      STEP_WAIT};
            STEP_MLOOP:  w = '{OP_MLOOP,  COND_MONTH_MORE, STEP_MLOOP};
            STEP_EMIT:   w = '{OP_EMIT,   COND_OUT_BUSY,   STEP_EMIT};
            STEP_RETURN: w = '{OP_NOP,    COND_ALWAYS,     STEP_WAIT};
            default:     w = '{OP_NOP,    COND_ALWAYS,     STEP_WAIT};
        endcase
        return w;
    endfunction

    // length of month m, february follows the leap flag
    function automatic logic [4:0] mon_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        case (m)
            4'd2:    n = leap ? 5'd29 : 5'd28;
            4'd4:    n = 5'd30;
            4'd6:    n = 5'd30;
            4'd9:    n = 5'd30;
            4'd11:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

    // days in a common year before the first of month m
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/gdad_sequencer.sv
// microcode sequencer of the date adder: step counter, control word table, jumps
// depends on gdad_pkg
module gdad_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  gdad_pkg::status_t status,
    output gdad_pkg::ucode_t  ctrl
);

    gdad_pkg::step_t step_reg;
    gdad_pkg::step_t step_next;
    logic            take;

    // control word of the current step
    assign ctrl = gdad_pkg::ucode_rom(step_reg);

    // jump condition
    always_comb begin
        case (ctrl.cond)
            gdad_pkg::COND_NEVER:      take = 1'b0;
            gdad_pkg::COND_ALWAYS:     take = 1'b1;
            gdad_pkg::COND_NO_INPUT:   take = !status.in_valid;
            gdad_pkg::COND_FIT_FIRST:  take = status.fit_first;
            gdad_pkg::COND_YEAR_MORE:  take = status.year_more;
            gdad_pkg::COND_MONTH_MORE: take = status.month_more;
            gdad_pkg::COND_OUT_BUSY:   take = status.out_busy;
            default:                   take = 1'b0;
        endcase
        step_next = take ? ctrl.target : gdad_pkg::step_t'(step_reg + 4'd1);
    end

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= gdad_pkg::STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

FILE: rtl/gregorian_date_add_days_unit.sv
// Gregorian date adder: adds a day count (0..65535) to a date (day, month, year 1..9999).
// One item at a time: s_ready is high only while the sequencer waits for a beat. The year
// loop makes Y (0..about 180) passes, one year a cycle, and Y is 0 when the start year holds
// the whole count. The month loop makes M (1..12) passes, one month a cycle. After the result
// is written the sequencer passes through its return step before it waits for the next beat,
// and a result that finds the previous one still waiting for m_ready stalls until it leaves.
// Out-of-range fields are clamped first: day 0 becomes 1, a day past its month becomes the
// month's last day, and month and year are clamped to their range. A result past 31 December
// 9999 saturates to that date with year_overflow set. The result sits in an output register,
// so the next beat is taken while it waits for m_ready.
// Depends on gdad_pkg and gdad_sequencer.
module gregorian_date_add_days_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gdad_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gdad_pkg::out_beat_t m_data
);

    gdad_pkg::ucode_t    ctrl;
    gdad_pkg::status_t   status;

    logic [4:0]          day_reg,  day_next;
    logic [3:0]          mon_reg,  mon_next;
    logic [13:0]         year_reg, year_next;
    logic [15:0]         rem_reg,  rem_next;
    logic [8:0]          off_reg,  off_next;
    logic [6:0]          q_reg,    q_next;
    logic [6:0]          ymod_reg, ymod_next;
    logic [1:0]          cq_reg,   cq_next;
    logic                ovf_reg,  ovf_next;
    gdad_pkg::out_beat_t out_reg,  out_next;
    logic                m_valid_reg, m_valid_next;

    logic                leap;
    logic [8:0]          ylen;
    logic [8:0]          first_gap;
    logic [4:0]          mlen;
    logic                year_ovf;
    logic                year_fit;
    logic                out_busy;
    logic [26:0]         recip_prod;
    logic [13:0]         cent_prod;
    logic [13:0]         year_inc;
    logic [6:0]          ymod_inc;
    logic [1:0]          cq_inc;

    gdad_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    // calendar flags of the current year and month
    assign leap      = (year_reg[1:0] == 2'd0) && ((ymod_reg != 7'd0) || (cq_reg == 2'd0));
    assign ylen      = leap ? gdad_pkg::DAYS_LEAP : gdad_pkg::DAYS_COMMON;
    assign first_gap = ylen - off_reg;
    assign mlen      = gdad_pkg::mon_len(mon_reg, leap);
    assign year_ovf  = year_reg > gdad_pkg::YEAR_MAX;
    assign year_fit  = rem_reg <= {7'd0, ylen};
    assign out_busy  = m_valid_reg && !m_ready;

    assign status.in_valid   = s_valid;
    assign status.fit_first  = rem_reg <= {7'd0, first_gap};
    assign status.year_more  = !year_ovf && !year_fit;
    assign status.month_more = (mon_reg != gdad_pkg::MONTH_MAX) && (off_reg > {4'd0, mlen});
    assign status.out_busy   = out_busy;

    // century split of the year by reciprocal multiply
    assign recip_prod = {13'd0, year_reg} * {14'd0, gdad_pkg::RECIP_MUL};
    assign cent_prod  = {7'd0, q_reg} * {7'd0, gdad_pkg::CENTURY};

    // next year with its year-in-century and century-mod-4 counters
    assign year_inc = year_reg + 14'd1;
    assign ymod_inc = (ymod_reg == 7'd99) ? 7'd0 : ymod_reg + 7'd1;
    assign cq_inc   = (ymod_reg == 7'd99) ? cq_reg + 2'd1 : cq_reg;

    assign s_ready = (ctrl.op == gdad_pkg::OP_LOAD);

    // datapath driven by the control word
    always_comb begin
        day_next     = day_reg;
        mon_next     = mon_reg;
        year_next    = year_reg;
        rem_next     = rem_reg;
        off_next     = off_reg;
        q_next       = q_reg;
        ymod_next    = ymod_reg;
        cq_next      = cq_reg;
        ovf_next     = ovf_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (ctrl.op)
            gdad_pkg::OP_LOAD: begin
                day_next  = (s_data.start_day == 5'd0) ? 5'd1 : s_data.start_day;
                if (s_data.start_month == 4'd0) begin
                    mon_next = 4'd1;
                end else if (s_data.start_month > gdad_pkg::MONTH_MAX) begin
                    mon_next = gdad_pkg::MONTH_MAX;
                end else begin
                    mon_next = s_data.start_month;
                end
                if (s_data.start_year == 14'd0) begin
                    year_next = 14'd1;
                end else if (s_data.start_year > gdad_pkg::YEAR_MAX) begin
                    year_next = gdad_pkg::YEAR_MAX;
                end else begin
                    year_next = s_data.start_year;
                end
                rem_next = s_data.days_to_add;
                ovf_next = 1'b0;
            end
            gdad_pkg::OP_QDIV: begin
                q_next = recip_prod[gdad_pkg::RECIP_SHIFT +: 7];
            end
            gdad_pkg::OP_REM: begin
                ymod_next = 7'(year_reg - cent_prod);
                cq_next   = q_reg[1:0];
            end
            gdad_pkg::OP_DCLAMP: begin
                if (day_reg > mlen) begin
                    day_next = mlen;
                end
            end
            gdad_pkg::OP_OFFSET: begin
                off_next = gdad_pkg::days_before(mon_reg) + {4'd0, day_reg}
                         + {8'd0, (leap && (mon_reg > 4'd2))};
            end
            gdad_pkg::OP_FIRST: begin
                if (status.fit_first) begin
                    off_next = off_reg + rem_reg[8:0];
                end else begin
                    rem_next  = rem_reg - {7'd0, first_gap};
                    year_next = year_inc;
                    ymod_next = ymod_inc;
                    cq_next   = cq_inc;
                end
            end
            gdad_pkg::OP_YLOOP: begin
                if (year_ovf) begin
                    ovf_next = 1'b1;
                end else if (year_fit) begin
                    off_next = rem_reg[8:0];
                end else begin
                    rem_next  = rem_reg - {7'd0, ylen};
                    year_next = year_inc;
                    ymod_next = ymod_inc;
                    cq_next   = cq_inc;
                end
            end
            gdad_pkg::OP_MINIT: begin
                mon_next = 4'd1;
            end
            gdad_pkg::OP_MLOOP: begin
                if (status.month_more) begin
                    off_next = off_reg - {4'd0, mlen};
                    mon_next = mon_reg + 4'd1;
                end
            end
            gdad_pkg::OP_EMIT: begin
                if (!out_busy) begin
                    m_valid_next = 1'b1;
                    if (ovf_reg) begin
                        out_next = '{gdad_pkg::DAY_MAX, gdad_pkg::MONTH_MAX,
                                     gdad_pkg::YEAR_MAX, 1'b1};
                    end else begin
                        out_next = '{off_reg[4:0], mon_reg, year_reg, 1'b0};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // payload registers
    always_ff @(posedge aclk) begin
        day_reg  <= day_next;
        mon_reg  <= mon_next;
        year_reg <= year_next;
        rem_reg  <= rem_next;
        off_reg  <= off_next;
        q_reg    <= q_next;
        ymod_reg <= ymod_next;
        cq_reg   <= cq_next;
        ovf_reg  <= ovf_next;
        out_reg  <= out_next;
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: rtl/gdad_checker.sv
// port-level checks of the date adder and the bind that attaches them
// depends on gdad_pkg and gregorian_date_add_days_unit_macros.svh
`include "gregorian_date_add_days_unit_macros.svh"

module gdad_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input gdad_pkg::in_beat_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input gdad_pkg::out_beat_t m_data
);

    // a stalled input beat holds
    `GDAD_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_data))

    // a stalled result beat holds
    `GDAD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // one beat in flight: no new beat right after one is taken
    `GDAD_ASSERT_NEXT(a_one_inflight, aclk, aresetn, s_valid && s_ready, !s_ready)

    // result fields lie in range: month 1..12, year 1..9999, day at least 1
    `GDAD_ASSERT_NOW(a_out_range, aclk, aresetn, m_valid, (m_data.result_month >= 4'd1) && (m_data.result_month <= gdad_pkg::MONTH_MAX) && (m_data.result_day >= 5'd1) && (m_data.result_year >= 14'd1) && (m_data.result_year <= gdad_pkg::YEAR_MAX))

    // overflow gives the saturated last date
    `GDAD_ASSERT_NOW(a_ovf_sat, aclk, aresetn, m_valid && m_data.year_overflow, (m_data.result_day == gdad_pkg::DAY_MAX) && (m_data.result_month == gdad_pkg::MONTH_MAX) && (m_data.result_year == gdad_pkg::YEAR_MAX))

endmodule

bind gregorian_date_add_days_unit gdad_checker u_gdad_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
